[src/lbp_pkg.sv]
// ---------------------------------------------------------------------------
// lbp_pkg: shared types and constants of the LSB-first bit packer
// Field widths, default chunk size and the structs passed between stages.
// ---------------------------------------------------------------------------
package lbp_pkg;

   // Default widest chunk, in bits
   localparam int DEF_MAX_CHUNK_BITS = 64;

   // Fixed field widths
   localparam int COUNT_W   = 7;
   localparam int BYTE_W    = 8;
   localparam int VBITS_W   = 4;
   localparam int PEND_W    = 7;
   localparam int PCNT_W    = 3;
   localparam int RSP_TDATA_W = 16;

   // Queue depth between front and back
   localparam int QUEUE_DEPTH = 2;

   // Control part of a classified request
   typedef struct packed {
      logic [COUNT_W-1:0] bit_cnt;
      logic               eom;
   } item_ctl_type;

   // One result beat
   typedef struct packed {
      logic               msg_end;
      logic               last;
      logic [VBITS_W-1:0] valid_bits;
      logic [BYTE_W-1:0]  out_byte;
   } rsp_beat_type;

endpackage

[src/lsb_first_bit_packer.sv]
// ---------------------------------------------------------------------------
// lsb_first_bit_packer: LSB-first bit stream packer
// Each request appends up to MAX_CHUNK_BITS bits, bit 0 first, to a byte
// stream. The back end emits one result byte per clock while the sink does
// not stall, and a request holds it until every result byte it yields has
// been emitted; a request that yields none still passes through it. That
// pace is set by the single byte lane of the sequencer. A two-entry queue
// lets new requests be accepted while earlier ones are still being emitted,
// and a registered output holds a result while the sink stalls. tlast on a
// request flushes the partial byte; bit counts above MAX_CHUNK_BITS are
// clamped.
// ---------------------------------------------------------------------------
module lsb_first_bit_packer
   import lbp_pkg::*;
#(
   parameter int MAX_CHUNK_BITS = DEF_MAX_CHUNK_BITS,
   localparam int REQ_TDATA_W   = ((MAX_CHUNK_BITS + COUNT_W + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request: chunk_value, bit_count, zero pad (lowest bit up)
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   // result: out_byte, valid_bits, zero pad (lowest bit up)
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // result tuser: message_end
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   logic [MAX_CHUNK_BITS-1:0] fr_data;
   item_ctl_type              fr_ctl;
   logic                      q_valid, q_ready;
   logic [MAX_CHUNK_BITS-1:0] q_data;
   item_ctl_type              q_ctl;
   rsp_beat_type              beat;

   lbp_front #(
      .MAX_CHUNK_BITS (MAX_CHUNK_BITS),
      .TDATA_W        (REQ_TDATA_W)
   ) u_front (
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .item_data (fr_data),
      .item_ctl  (fr_ctl)
   );

   lbp_queue #(
      .MAX_CHUNK_BITS (MAX_CHUNK_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (fr_data),
      .in_ctl    (fr_ctl),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data),
      .out_ctl   (q_ctl)
   );

   lbp_back #(
      .MAX_CHUNK_BITS (MAX_CHUNK_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .q_ctl     (q_ctl),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_beat  (beat)
   );

   // Result packing
   assign rsp_tdata = {(RSP_TDATA_W - BYTE_W - VBITS_W)'(0), beat.valid_bits, beat.out_byte};
   assign rsp_tuser = beat.msg_end;
   assign rsp_tlast = beat.last;

endmodule

[src/lbp_front.sv]
// ---------------------------------------------------------------------------
// lbp_front: request classifier
// Unpacks a request, saturates its bit count and clears bits above the count.
// ---------------------------------------------------------------------------
module lbp_front
   import lbp_pkg::*;
#(
   parameter int MAX_CHUNK_BITS = DEF_MAX_CHUNK_BITS,
   parameter int TDATA_W        = 72
) (
   input  logic [TDATA_W-1:0]        req_tdata,
   input  logic                      req_tlast,
   output logic [MAX_CHUNK_BITS-1:0] item_data,
   output item_ctl_type              item_ctl
);

   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_CHUNK_BITS);

   logic [MAX_CHUNK_BITS-1:0] chunk_value;
   logic [COUNT_W-1:0]        bit_count;
   logic [COUNT_W-1:0]        cnt_sat;
   logic [MAX_CHUNK_BITS-1:0] keep_mask;

   assign chunk_value = req_tdata[MAX_CHUNK_BITS-1:0];
   assign bit_count   = req_tdata[MAX_CHUNK_BITS+COUNT_W-1:MAX_CHUNK_BITS];

   // Oversized counts clamp to the widest chunk
   assign cnt_sat = (bit_count > MAX_CNT) ? MAX_CNT : bit_count;

   // Keep only the low cnt_sat bits; a full-width count keeps all
   assign keep_mask = ~({MAX_CHUNK_BITS{1'b1}} << cnt_sat);

   assign item_data        = chunk_value & keep_mask;
   assign item_ctl.bit_cnt = cnt_sat;
   assign item_ctl.eom     = req_tlast;

endmodule

[src/lbp_queue.sv]
// ---------------------------------------------------------------------------
// lbp_queue: small request queue
// Two-entry FIFO that decouples the classifier from the byte sequencer.
// ---------------------------------------------------------------------------
module lbp_queue
   import lbp_pkg::*;
#(
   parameter int MAX_CHUNK_BITS = DEF_MAX_CHUNK_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [MAX_CHUNK_BITS-1:0] in_data,
   input  item_ctl_type              in_ctl,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [MAX_CHUNK_BITS-1:0] out_data,
   output item_ctl_type              out_ctl
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   logic [MAX_CHUNK_BITS-1:0] data_mem [QUEUE_DEPTH];
   item_ctl_type              ctl_mem  [QUEUE_DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      push, pop;

   assign in_ready  = (cnt_ff != FULL_CNT);
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   assign out_data = data_mem[rd_ptr_ff];
   assign out_ctl  = ctl_mem[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         data_mem[wr_ptr_ff] <= in_data;
         ctl_mem[wr_ptr_ff]  <= in_ctl;
      end
   end

endmodule

[src/lbp_back.sv]
// ---------------------------------------------------------------------------
// lbp_back: byte sequencer
// Merges chunk bits with the pending partial byte, emits one byte per cycle
// into a free output register and flushes the partial byte at message end.
// ---------------------------------------------------------------------------
module lbp_back
   import lbp_pkg::*;
#(
   parameter int MAX_CHUNK_BITS = DEF_MAX_CHUNK_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_ready,
   input  logic [MAX_CHUNK_BITS-1:0] q_data,
   input  item_ctl_type              q_ctl,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_beat_type              rsp_beat
);

   localparam logic [COUNT_W-1:0] BYTE_CNT = COUNT_W'(BYTE_W);

   logic                      busy_ff, busy_in;
   logic                      eom_ff, eom_in;
   logic [MAX_CHUNK_BITS-1:0] data_ff, data_in;
   logic [COUNT_W-1:0]        rem_ff, rem_in;
   logic [PEND_W-1:0]         pend_ff, pend_in;
   logic [PCNT_W-1:0]         pcnt_ff, pcnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_beat_type              rsp_beat_ff, rsp_beat_in;

   logic                      can_out, step, finish, emit, pop;
   logic [COUNT_W:0]          sum;
   logic                      full;
   logic [VBITS_W-1:0]        need;
   logic [COUNT_W-1:0]        rem_after;
   logic [MAX_CHUNK_BITS-1:0] data_sh;
   logic [BYTE_W-1:0]         byte_mix;

   // Output register frees up when empty or being taken
   assign can_out = !rsp_valid_ff || rsp_ready;
   assign step    = busy_ff && can_out;

   // Datapath for the current step
   assign sum       = {1'b0, rem_ff} + (COUNT_W+1)'(pcnt_ff);
   assign full      = (sum >= (COUNT_W+1)'(BYTE_W));
   assign need      = VBITS_W'(BYTE_W) - VBITS_W'(pcnt_ff);
   assign rem_after = rem_ff - COUNT_W'(need);
   assign data_sh   = data_ff >> need;
   assign byte_mix  = {1'b0, pend_ff} | (data_ff[BYTE_W-1:0] << pcnt_ff);

   // Step sequencing: full bytes, then merge or flush of the remainder
   always_comb begin
      finish      = 1'b0;
      emit        = 1'b0;
      data_in     = data_ff;
      rem_in      = rem_ff;
      pend_in     = pend_ff;
      pcnt_in     = pcnt_ff;
      rsp_beat_in = rsp_beat_ff;
      if (step) begin
         if (full) begin
            // a full byte; the item ends here unless bits or a flush follow
            emit                   = 1'b1;
            finish                 = (rem_after < BYTE_CNT) && !(eom_ff && (rem_after != '0));
            rsp_beat_in.out_byte   = byte_mix;
            rsp_beat_in.valid_bits = VBITS_W'(BYTE_W);
            rsp_beat_in.last       = finish;
            rsp_beat_in.msg_end    = finish && eom_ff;
            data_in                = data_sh;
            rem_in                 = rem_after;
            if (finish) begin
               pend_in = data_sh[PEND_W-1:0];
               pcnt_in = rem_after[PCNT_W-1:0];
            end else begin
               pend_in = '0;
               pcnt_in = '0;
            end
         end else begin
            finish = 1'b1;
            if (eom_ff && (sum != '0)) begin
               // flush the partial byte
               emit                   = 1'b1;
               rsp_beat_in.out_byte   = byte_mix;
               rsp_beat_in.valid_bits = sum[VBITS_W-1:0];
               rsp_beat_in.last       = 1'b1;
               rsp_beat_in.msg_end    = 1'b1;
               pend_in                = '0;
               pcnt_in                = '0;
            end else if (eom_ff) begin
               pend_in = '0;
               pcnt_in = '0;
            end else begin
               pend_in = byte_mix[PEND_W-1:0];
               pcnt_in = sum[PCNT_W-1:0];
            end
         end
      end
      // next request loads as the current one finishes
      if (pop) begin
         data_in = q_data;
         rem_in  = q_ctl.bit_cnt;
      end
   end

   assign q_ready = !busy_ff || (step && finish);
   assign pop     = q_valid && q_ready;

   always_comb begin
      busy_in = busy_ff;
      eom_in  = eom_ff;
      if (pop) begin
         busy_in = 1'b1;
         eom_in  = q_ctl.eom;
      end else if (step && finish) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= '0;
         pcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         pcnt_ff      <= pcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      eom_ff      <= eom_in;
      data_ff     <= data_in;
      rem_ff      <= rem_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

[tb/sv/lsb_first_bit_packer_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsb_first_bit_packer_checker: result predictor and scoreboard
// Watches the request and result channels of the bit packer. Each accepted
// request is packed into expected stream bytes by a local model of the
// leftover-bit state; each accepted result is compared with the oldest one.
// ---------------------------------------------------------------------------
module lsb_first_bit_packer_checker
   import lbp_pkg::*;
#(
   parameter int MAX_CHUNK_BITS = DEF_MAX_CHUNK_BITS,
   parameter int REQ_TDATA_W    = ((MAX_CHUNK_BITS + COUNT_W + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   rsp_tlast,
   output int                     fail_count,
   output int                     results_due
);

   // leftover bits of the stream, earliest in bit 0
   logic [PEND_W-1:0] pend_bits;
   logic [PCNT_W-1:0] pend_cnt;

   // bytes still to come, oldest first
   rsp_beat_type expected_beats[$];
   int mismatches;

   // Pack one chunk onto the leftover bits and queue every byte it yields
   task automatic append_chunk(input logic [MAX_CHUNK_BITS-1:0] value,
                               input logic [COUNT_W-1:0] cnt_in,
                               input logic eom);
      logic [MAX_CHUNK_BITS+7:0] acc;
      logic [MAX_CHUNK_BITS-1:0] chunk;
      int unsigned cnt;
      int unsigned total;
      int unsigned nfull;
      int first;
      rsp_beat_type beat;
      cnt   = (cnt_in > MAX_CHUNK_BITS) ? MAX_CHUNK_BITS : cnt_in;
      chunk = value;
      if (cnt < MAX_CHUNK_BITS)
         chunk = chunk & ((MAX_CHUNK_BITS'(1) << cnt) - MAX_CHUNK_BITS'(1));
      acc   = (($bits(acc))'(chunk) << pend_cnt) | ($bits(acc))'(pend_bits);
      total = pend_cnt + cnt;
      nfull = total / BYTE_W;
      first = expected_beats.size();
      for (int i = 0; i < nfull; i++) begin
         beat            = '0;
         beat.out_byte   = acc[i*BYTE_W +: BYTE_W];
         beat.valid_bits = VBITS_W'(BYTE_W);
         expected_beats.push_back(beat);
      end
      // bits above total are zero, so the next seven are the leftover
      pend_bits = acc[nfull*BYTE_W +: PEND_W];
      pend_cnt  = PCNT_W'(total % BYTE_W);

      // end of message: flush a partial byte, or mark the last full one
      if (eom) begin
         if (pend_cnt != 0) begin
            beat            = '0;
            beat.out_byte   = {1'b0, pend_bits};
            beat.valid_bits = VBITS_W'(pend_cnt);
            beat.msg_end    = 1'b1;
            expected_beats.push_back(beat);
         end else if (nfull > 0) begin
            beat         = expected_beats.pop_back();
            beat.msg_end = 1'b1;
            expected_beats.push_back(beat);
         end
         pend_bits = '0;
         pend_cnt  = '0;
      end

      if (expected_beats.size() > first) begin
         beat      = expected_beats.pop_back();
         beat.last = 1'b1;
         expected_beats.push_back(beat);
      end
   endtask

   // Compare a result first, then predict from a request at the same edge
   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         expected_beats.delete();
         pend_bits = '0;
         pend_cnt  = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected result: out_byte %0h valid_bits %0d",
                      rsp_tdata[BYTE_W-1:0], rsp_tdata[BYTE_W +: VBITS_W]);
               mismatches++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_tdata[BYTE_W-1:0] !== want.out_byte) begin
                  $error("out_byte: expected %0h, actual %0h",
                         want.out_byte, rsp_tdata[BYTE_W-1:0]);
                  mismatches++;
               end
               if (rsp_tdata[BYTE_W +: VBITS_W] !== want.valid_bits) begin
                  $error("valid_bits: expected %0d, actual %0d",
                         want.valid_bits, rsp_tdata[BYTE_W +: VBITS_W]);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_of_run: expected %0b, actual %0b", want.last, rsp_tlast);
                  mismatches++;
               end
               if (rsp_tuser !== want.msg_end) begin
                  $error("message_end: expected %0b, actual %0b",
                         want.msg_end, rsp_tuser);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            append_chunk(req_tdata[MAX_CHUNK_BITS-1:0],
                         req_tdata[MAX_CHUNK_BITS +: COUNT_W], req_tlast);
      end
      fail_count  <= mismatches;
      results_due <= expected_beats.size();
   end

endmodule

[tb/sv/lsb_first_bit_packer_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsb_first_bit_packer_tb: stimulus and verdict for the bit packer
// Drives directed corner chunks and then random chunks through four
// flow-control phases, with random stalls on the result side; the checker
// predicts and compares every result byte.
// ---------------------------------------------------------------------------
module lsb_first_bit_packer_tb;
   import lbp_pkg::*;

   localparam int CHUNK_W     = DEF_MAX_CHUNK_BITS;
   localparam int REQ_TDATA_W = ((CHUNK_W + COUNT_W + 7) / 8) * 8;
   localparam int RANDOM_REQS = 92;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   int                     fail_count;
   int                     results_due;

   // percent chance per cycle of an idle sender / a stalled receiver
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   lsb_first_bit_packer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   lsb_first_bit_packer_checker #(
      .MAX_CHUNK_BITS (CHUNK_W)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: random stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Offer one request and hold it until accepted, then maybe go idle
   task automatic send_chunk(input logic [CHUNK_W-1:0] value,
                             input logic [COUNT_W-1:0] cnt,
                             input logic eom);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({cnt, value});
      req_tlast  <= eom;
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Hold off the sender until every expected byte has come
   task automatic drain;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // Random chunk: mostly legal sizes, some zero, tiny and oversized
   task automatic send_random;
      logic [CHUNK_W-1:0] value;
      logic [COUNT_W-1:0] cnt;
      int pick;
      value = {$urandom, $urandom};
      pick  = $urandom_range(99);
      if (pick < 60)
         cnt = COUNT_W'($urandom_range(CHUNK_W, 1));
      else if (pick < 72)
         cnt = COUNT_W'($urandom_range(7, 1));
      else if (pick < 82)
         cnt = '0;
      else if (pick < 90)
         cnt = COUNT_W'(CHUNK_W);
      else
         cnt = COUNT_W'($urandom_range(127, CHUNK_W + 1));
      send_chunk(value, cnt, $urandom_range(99) < 25);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_chunk('1, 7'd64, 1'b0);
      send_chunk('0, 7'd64, 1'b0);
      send_chunk(64'd1, 7'd1, 1'b0);
      // bits above the count are ignored
      send_chunk('1, 7'd3, 1'b0);
      // zero count without and with a flush of pending bits
      send_chunk(64'h0, 7'd0, 1'b0);
      send_chunk('1, 7'd0, 1'b1);
      // flush with nothing pending and no byte: no result
      send_chunk(64'h0, 7'd0, 1'b1);
      // flush with nothing pending after a full byte
      send_chunk(64'hA5, 7'd8, 1'b1);
      send_chunk(64'h55, 7'd7, 1'b1);
      // oversized counts clamp
      send_chunk('1, 7'd65, 1'b0);
      send_chunk(64'h0123_4567_89AB_CDEF, 7'd127, 1'b1);
      // nine results from one request
      send_chunk(64'd5, 7'd3, 1'b0);
      send_chunk(64'hDEAD_BEEF_CAFE_F00D, 7'd64, 1'b1);
      send_chunk(64'd1, 7'd1, 1'b1);
      send_chunk(64'h8000_0000_0000_0000, 7'd64, 1'b0);
      send_chunk(64'd6, 7'd63, 1'b1);
      send_chunk(64'h5555_5555_5555_5555, 7'd100, 1'b0);
      send_chunk(64'hAAAA_AAAA_AAAA_AAAA, 7'd57, 1'b1);
      drain();

      // random phases: free flow, idle sender, stalled sink, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 69; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin send_idle_pct = 22; rsp_stall_pct = 22; end
         endcase
         for (int i = 0; i < RANDOM_REQS / 4; i++)
            send_random();
         drain();
      end

      rsp_stall_pct = 0;
      repeat (40) @(posedge clock);
      if (fail_count == 0 && results_due == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400_000;
      $display("simulation failed");
      $finish;
   end

endmodule

[files.f]
src/lbp_pkg.sv
src/lbp_front.sv
src/lbp_queue.sv
src/lbp_back.sv
src/lsb_first_bit_packer.sv
tb/sv/lsb_first_bit_packer_checker.sv
tb/sv/lsb_first_bit_packer_tb.sv
